// File: hw/rtl/bba_pkg.sv
// Shared types, constants and command/status structs of the bitmap block allocator.
`default_nettype none

package bba_pkg;

  localparam int unsigned MAX_BLOCKS_DEF  = 1024;
  localparam int unsigned BLOCK_BYTES_DEF = 4096;

  // Fixed field widths.
  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned PADDR_W = 4;

  // One free-map word holds 64 block bits, LSB is the lowest block.
  localparam int unsigned LOG_WORD  = 6;
  localparam int unsigned WORD_BITS = 1 << LOG_WORD;

  localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

  // Register index, taken from paddr[3].
  localparam logic REG_TABLE_BASE  = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  // Request actions.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MUL,
    S_ADD,
    S_FSUB,
    S_FCHK,
    S_FDIV,
    S_FRD,
    S_FUPD,
    S_PUSH
  } state_e;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic scan;
    logic mul;
    logic add;
    logic sub;
    logic range_chk;
    logic div;
    logic frd;
    logic fupd;
    logic push;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_hit;
    logic scan_fail;
    logic in_range;
    logic slot_free;
  } ctl_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bba_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/bba_cfg.sv
// APB-style configuration registers: table base and block count.
`default_nettype none

module bba_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bba_pkg::PADDR_W-1:0]  paddr,
  input  logic [bba_pkg::DATA_W-1:0]   pwdata,
  output logic [bba_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output logic [bba_pkg::ADDR_W-1:0]   table_base_o,
  output logic [bba_pkg::CNT_W-1:0]    block_count_o
);

  logic [bba_pkg::ADDR_W-1:0] base_q, base_d;
  logic [bba_pkg::CNT_W-1:0]  count_q, count_d;
  logic                       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    base_d  = base_q;
    count_d = count_q;
    if (wr_en) begin
      unique case (paddr[3])
        bba_pkg::REG_TABLE_BASE:  base_d  = pwdata;
        bba_pkg::REG_BLOCK_COUNT: count_d = pwdata[bba_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      bba_pkg::REG_TABLE_BASE:  prdata = base_q;
      bba_pkg::REG_BLOCK_COUNT: prdata = bba_pkg::DATA_W'(count_q);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      count_q <= bba_pkg::COUNT_RESET;
    end else begin
      base_q  <= base_d;
      count_q <= count_d;
    end
  end

  assign table_base_o  = base_q;
  assign block_count_o = count_q;

endmodule

`default_nettype wire

// File: hw/rtl/bba_ctrl.sv
// Controller state machine of the bitmap block allocator.
`default_nettype none

module bba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              action_i,
  output logic              in_ready_o,
  input  bba_pkg::ctl_sts_t sts_i,
  output bba_pkg::ctl_cmd_t cmd_o
);

  bba_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bba_pkg::S_CLEAR: if (sts_i.clear_last) state_d = bba_pkg::S_IDLE;
      bba_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = (action_i == bba_pkg::ACT_FREE) ? bba_pkg::S_FSUB : bba_pkg::S_SCAN;
        end
      end
      bba_pkg::S_SCAN: begin
        if (sts_i.scan_hit) begin
          state_d = bba_pkg::S_MUL;
        end else if (sts_i.scan_fail) begin
          state_d = bba_pkg::S_PUSH;
        end
      end
      bba_pkg::S_MUL:  state_d = bba_pkg::S_ADD;
      bba_pkg::S_ADD:  state_d = bba_pkg::S_PUSH;
      bba_pkg::S_FSUB: state_d = bba_pkg::S_FCHK;
      bba_pkg::S_FCHK: state_d = sts_i.in_range ? bba_pkg::S_FDIV : bba_pkg::S_PUSH;
      bba_pkg::S_FDIV: state_d = bba_pkg::S_FRD;
      bba_pkg::S_FRD:  state_d = bba_pkg::S_FUPD;
      bba_pkg::S_FUPD: state_d = bba_pkg::S_PUSH;
      bba_pkg::S_PUSH: if (sts_i.slot_free) state_d = bba_pkg::S_IDLE;
      default:         state_d = bba_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      bba_pkg::S_CLEAR: cmd_o.clr_step = 1'b1;
      bba_pkg::S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      bba_pkg::S_SCAN: cmd_o.scan      = 1'b1;
      bba_pkg::S_MUL:  cmd_o.mul       = 1'b1;
      bba_pkg::S_ADD:  cmd_o.add       = 1'b1;
      bba_pkg::S_FSUB: cmd_o.sub       = 1'b1;
      bba_pkg::S_FCHK: cmd_o.range_chk = 1'b1;
      bba_pkg::S_FDIV: cmd_o.div       = 1'b1;
      bba_pkg::S_FRD:  cmd_o.frd       = 1'b1;
      bba_pkg::S_FUPD: cmd_o.fupd      = 1'b1;
      bba_pkg::S_PUSH: cmd_o.push      = sts_i.slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bba_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bba_datapath.sv
// Datapath: free map, word scan, address multiply-add, reciprocal divide and result register.
`default_nettype none

module bba_datapath #(
  parameter int unsigned MAX_BLOCKS  = bba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned BLOCK_BYTES = bba_pkg::BLOCK_BYTES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bba_pkg::ctl_cmd_t          cmd_i,
  output bba_pkg::ctl_sts_t          sts_o,
  input  logic [bba_pkg::ADDR_W-1:0] address_i,
  input  logic [bba_pkg::ADDR_W-1:0] table_base_i,
  input  logic [bba_pkg::CNT_W-1:0]  block_count_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [bba_pkg::ADDR_W-1:0] block_address_o,
  output logic                       ok_o
);

  localparam int unsigned WB    = bba_pkg::WORD_BITS;
  localparam int unsigned LW    = bba_pkg::LOG_WORD;
  localparam int unsigned CW    = bba_pkg::CNT_W;
  localparam int unsigned XW    = bba_pkg::ADDR_W;
  localparam int unsigned WORDS = (MAX_BLOCKS + WB - 1) / WB;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned SW    = (AW + LW > CW) ? AW + LW : CW;
  localparam int unsigned BBW   = $clog2(BLOCK_BYTES + 1);
  localparam int unsigned RW    = CW + BBW;
  localparam int unsigned PW    = SW + BBW;

  // Exact floor division of an RW-bit offset by the block size: multiply by the
  // rounded-up reciprocal scaled by 2^RSH and keep the bits above RSH.
  localparam int unsigned LB      = $clog2(BLOCK_BYTES);
  localparam int unsigned RSH     = RW + LB;
  localparam int unsigned FPW     = 2 * RW + 1;
  localparam logic [63:0] RECIP64 =
    ((64'd1 << RSH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);
  localparam logic [RW:0] RECIP   = RECIP64[RW:0];

  // Effective count and search limit (whole groups of eight).
  logic [CW-1:0] eff_cnt, lim;
  logic [RW-1:0] lim_bytes;

  always_comb begin
    if (32'(block_count_i) > 32'(MAX_BLOCKS)) begin
      eff_cnt = CW'(MAX_BLOCKS);
    end else begin
      eff_cnt = block_count_i;
    end
  end

  assign lim       = {eff_cnt[CW-1:3], 3'b000};
  assign lim_bytes = RW'(eff_cnt) * RW'(BLOCK_BYTES);

  // Free-map RAM ports.
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [WB-1:0] ram_wdata, ram_rdata;

  bba_ram #(
    .WIDTH (WB),
    .DEPTH (WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Control registers.
  logic [AW-1:0]  clr_q, clr_d;
  logic [AW:0]    rd_ptr_q, rd_ptr_d;
  logic           pend_q, pend_d;
  logic [AW-1:0]  pend_ptr_q, pend_ptr_d;
  logic           out_valid_q, out_valid_d;

  // Payload registers.
  logic [XW-1:0] addr_q, addr_d;
  logic [SW-1:0] idx_q, idx_d;
  logic [PW-1:0] prod_q, prod_d;
  logic [XW-1:0] diff_q, diff_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [CW-1:0] quo_q, quo_d;
  logic [XW-1:0] res_addr_q, res_addr_d, out_addr_q, out_addr_d;
  logic          res_ok_q, res_ok_d, out_ok_q, out_ok_d;

  // Scan of the word read in the previous cycle.
  logic          rd_more, any_free, scan_hit, scan_fail, scan_issue;
  logic [WB-1:0] word_mask, hit_vec;
  logic [LW-1:0] pos;

  assign rd_more = (32'(rd_ptr_q) << LW) < 32'(lim);

  always_comb begin
    for (int j = 0; j < WB; j++) begin
      word_mask[j] = ((32'(pend_ptr_q) << LW) + 32'(j)) < 32'(lim);
    end
  end

  assign hit_vec  = ram_rdata & word_mask;
  assign any_free = |hit_vec;

  always_comb begin
    pos = '0;
    for (int j = WB - 1; j >= 0; j--) begin
      if (hit_vec[j]) pos = LW'(j);
    end
  end

  assign scan_hit   = pend_q & any_free;
  assign scan_fail  = ~rd_more & ~scan_hit;
  assign scan_issue = cmd_i.scan & rd_more & ~scan_hit;

  // Free path: range check, then the block index from one reciprocal multiply.
  logic           in_range;
  logic [FPW-1:0] fprod;
  logic [SW-1:0]  fidx;
  logic [AW-1:0]  fword;
  logic [LW-1:0]  fbit;
  logic           slot_free;

  assign in_range  = diff_q < XW'(lim_bytes);
  assign fprod     = FPW'(rem_q) * FPW'(RECIP);
  assign fidx      = SW'(quo_q);
  assign fword     = fidx[LW +: AW];
  assign fbit      = fidx[LW-1:0];
  assign slot_free = ~out_valid_q | out_ready_i;

  always_comb begin
    clr_d       = clr_q;
    rd_ptr_d    = rd_ptr_q;
    pend_d      = pend_q;
    pend_ptr_d  = pend_ptr_q;
    out_valid_d = out_valid_q;
    addr_d      = addr_q;
    idx_d       = idx_q;
    prod_d      = prod_q;
    diff_d      = diff_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    res_addr_d  = res_addr_q;
    res_ok_d    = res_ok_q;
    out_addr_d  = out_addr_q;
    out_ok_d    = out_ok_q;

    if (cmd_i.clr_step) clr_d = clr_q + 1'b1;

    if (cmd_i.accept) begin
      addr_d   = address_i;
      rd_ptr_d = '0;
      pend_d   = 1'b0;
    end

    if (cmd_i.scan) begin
      pend_d = scan_issue;
      if (scan_issue) begin
        pend_ptr_d = rd_ptr_q[AW-1:0];
        rd_ptr_d   = rd_ptr_q + 1'b1;
      end
      if (scan_hit) begin
        idx_d = SW'({pend_ptr_q, pos});
      end else if (scan_fail) begin
        res_addr_d = '1;
        res_ok_d   = 1'b0;
      end
    end

    if (cmd_i.mul) prod_d = PW'(idx_q) * PW'(BLOCK_BYTES);

    if (cmd_i.add) begin
      res_addr_d = table_base_i + XW'(prod_q);
      res_ok_d   = 1'b1;
    end

    if (cmd_i.sub) diff_d = addr_q - table_base_i;

    if (cmd_i.range_chk) begin
      if (in_range) begin
        rem_d = diff_q[RW-1:0];
      end else begin
        res_addr_d = '0;
        res_ok_d   = 1'b0;
      end
    end

    if (cmd_i.div) quo_d = fprod[RSH +: CW];

    if (cmd_i.fupd) begin
      res_addr_d = '0;
      res_ok_d   = ~ram_rdata[fbit];
    end

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_i.push) begin
      out_valid_d = 1'b1;
      out_addr_d  = res_addr_q;
      out_ok_d    = res_ok_q;
    end
  end

  // Map write: clearing pass, clearing an allocated bit, or setting a freed bit.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_q;
    ram_wdata = '1;
    if (cmd_i.clr_step) begin
      ram_we = 1'b1;
    end else if (cmd_i.scan && scan_hit) begin
      ram_we    = 1'b1;
      ram_waddr = pend_ptr_q;
      ram_wdata = ram_rdata & ~(WB'(1) << pos);
    end else if (cmd_i.fupd && !ram_rdata[fbit]) begin
      ram_we    = 1'b1;
      ram_waddr = fword;
      ram_wdata = ram_rdata | (WB'(1) << fbit);
    end
  end

  assign ram_re    = scan_issue | cmd_i.frd;
  assign ram_raddr = cmd_i.frd ? fword : rd_ptr_q[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      rd_ptr_q    <= '0;
      pend_q      <= 1'b0;
      pend_ptr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      clr_q       <= clr_d;
      rd_ptr_q    <= rd_ptr_d;
      pend_q      <= pend_d;
      pend_ptr_q  <= pend_ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    idx_q      <= idx_d;
    prod_q     <= prod_d;
    diff_q     <= diff_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    res_addr_q <= res_addr_d;
    res_ok_q   <= res_ok_d;
    out_addr_q <= out_addr_d;
    out_ok_q   <= out_ok_d;
  end

  assign sts_o.clear_last = (clr_q == AW'(WORDS - 1));
  assign sts_o.scan_hit   = scan_hit;
  assign sts_o.scan_fail  = scan_fail;
  assign sts_o.in_range   = in_range;
  assign sts_o.slot_free  = slot_free;

  assign out_valid_o     = out_valid_q;
  assign block_address_o = out_addr_q;
  assign ok_o            = out_ok_q;

endmodule

`default_nettype wire

// File: hw/rtl/bitmap_block_allocator.sv
// An allocate request scans the map word by word (64 blocks a word) up to the first free block,
// or through all searched blocks when none is free; a free request is checked for range first,
// and its map word is read and updated only when the address is in range.
// One request is in work at a time; the next is taken while the last result waits at the output.
// After reset a clearing pass writes the map free, one word per cycle, over ceil(MAX_BLOCKS / 64)
// words, taking no request meanwhile; table_base resets to 0, block_count 1024.
`default_nettype none

module bitmap_block_allocator #(
  parameter int unsigned MAX_BLOCKS  = bba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned BLOCK_BYTES = bba_pkg::BLOCK_BYTES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  // Request channel.
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        action_i,
  input  logic [bba_pkg::ADDR_W-1:0]  address_i,

  // Result channel.
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bba_pkg::ADDR_W-1:0]  block_address_o,
  output logic                        ok_o,

  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bba_pkg::PADDR_W-1:0] paddr,
  input  logic [bba_pkg::DATA_W-1:0]  pwdata,
  output logic [bba_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  // The free map holds one bit per block, 1 meaning free, packed 64 blocks to a RAM
  // word. An allocate request walks the words from block zero with a pipelined read:
  // the word read last cycle is masked to the searched range and priority encoded
  // while the next word is fetched. A hit clears the bit in the same cycle and the
  // block index goes through a multiply stage and an add stage to form the address.
  // A free request subtracts the base, checks the offset against count times block
  // size, divides by the block size with one multiply by its reciprocal, then reads
  // and updates the word holding that block.

  logic [bba_pkg::ADDR_W-1:0] table_base;
  logic [bba_pkg::CNT_W-1:0]  block_count;
  bba_pkg::ctl_cmd_t          cmd;
  bba_pkg::ctl_sts_t          sts;

  bba_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .table_base_o  (table_base),
    .block_count_o (block_count)
  );

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bba_datapath #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .address_i       (address_i),
    .table_base_i    (table_base),
    .block_count_i   (block_count),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .block_address_o (block_address_o),
    .ok_o            (ok_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/bba_checker.sv
// Port-level assertion checker for the bitmap block allocator, with its bind.
`default_nettype none

module bba_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [bba_pkg::ADDR_W-1:0] block_address_o,
  input logic                       ok_o
);

  // The clearing pass keeps requests out in the first cycle after reset.
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !in_ready_o)
    else $error("request ready during the map clearing pass");

  // Only one request is in work: ready drops right after an accept.
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second request taken while one is in work");

  // No result appears in the cycle right after a request is taken.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !$rose(out_valid_o))
    else $error("result raised one cycle after request");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(block_address_o) && $stable(ok_o)))
    else $error("stalled result changed");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);

`default_nettype wire
